// ----- design/bps_pkg.sv -----
// Shared types, constants and helpers for the byte pattern search block.
// Used by every module under design/; depends on nothing else.
package bps_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int MAX_BUFFER  = 65536;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 5;                        // holds 0..31, field width
    localparam int PIDX_W   = 4;                        // index into MAX_PATTERN bytes
    localparam int SEEN_W   = $clog2(MAX_BUFFER + 1);   // holds 0..MAX_BUFFER
    localparam int OFFSET_W = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 64;

    localparam logic [SEEN_W-1:0]   SEEN_LIMIT = SEEN_W'(MAX_BUFFER);
    localparam logic [SEEN_W-1:0]   OFFSET_SAT = SEEN_W'(2 ** OFFSET_W - 1);
    localparam logic [LEN_W-1:0]    LEN_MAX    = LEN_W'(MAX_PATTERN);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_CASE_FOLD      = CFG_IDX_W'(3);

    localparam logic [BYTE_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] ASCII_CASE    = 8'h20;

    typedef logic [MAX_PATTERN-1:0][BYTE_W-1:0] window_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } in_item_t;

    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] match_offset;
        logic                too_long;
    } out_item_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] pattern_low;
        logic [CFG_DATA_W-1:0] pattern_high;
        logic [LEN_W-1:0]      pattern_length;
        logic                  case_fold;
    } cfg_t;

    // ASCII upper case to lower case when folding is on
    function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                    input logic en);
        logic [BYTE_W-1:0] r;
        r = b;
        if (en && (b inside {[ASCII_UPPER_A:ASCII_UPPER_Z]}))
            r = b + ASCII_CASE;
        return r;
    endfunction

endpackage

// ----- design/byte_pattern_search.sv -----
// Top level of the byte pattern search block: buffer state, result forming.
// Depends on bps_pkg, bps_cfg_regs, bps_window_cmp and bps_out_buf.
//
//  channel  direction  handshake              payload
//  in       request in in_valid / in_ready    in_data  (in_item_t: data_byte, last_byte)
//  out      result out out_valid / out_ready  out_data (out_item_t: found, offset, too_long)
//  cfg      write in   cfg_valid / cfg_ready  cfg_index, cfg_data (64 bits)
//
// One request is taken every cycle while in_ready is high; its result, if any, is
// registered in the output register, or in the skid entry if the output is stalled;
// in_ready drops only while that entry is full. The per-byte path is window shift,
// 16-byte compare and counter update, all between the state registers and the result
// register. Reset clears the counters and flags, not the window, and sets
// pattern_length to 1. cfg_ready is always high; writes apply from the next request on.
module byte_pattern_search
    import bps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg;

    // per-buffer state
    window_t           window_reg, window_next;
    logic [SEEN_W-1:0] seen_reg, seen_next;
    logic              reported_reg, reported_next;
    logic              overflow_reg, overflow_next;

    logic              accept;
    logic              has_room;
    logic              push;
    out_item_t         push_data;
    logic [LEN_W-1:0]  len_eff;
    logic              hit;
    window_t           window_shift;
    logic [SEEN_W-1:0] seen_inc;
    logic [SEEN_W-1:0] start;

    bps_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // newest byte enters at position 0
    assign window_shift = {window_reg[MAX_PATTERN-2:0], in_data.data_byte};
    assign seen_inc     = seen_reg + SEEN_W'(1);
    assign start        = seen_inc - SEEN_W'(len_eff);

    bps_window_cmp u_cmp (
        .window  (window_shift),
        .cfg     (cfg),
        .len_eff (len_eff),
        .hit     (hit)
    );

    assign in_ready = has_room;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        window_next   = window_reg;
        seen_next     = seen_reg;
        reported_next = reported_reg;
        overflow_next = overflow_reg;
        push          = 1'b0;
        push_data     = '0;

        if (accept)
        begin
            if (!reported_reg && !overflow_reg)
            begin
                if (seen_reg == SEEN_LIMIT)
                begin
                    overflow_next = 1'b1;     // buffer past the counter limit
                end
                else
                begin
                    window_next = window_shift;
                    seen_next   = seen_inc;
                    if ((seen_inc >= SEEN_W'(len_eff)) && hit)
                    begin
                        push                   = 1'b1;
                        push_data.found        = 1'b1;
                        push_data.match_offset = (start > OFFSET_SAT) ?
                                                 OFFSET_SAT[OFFSET_W-1:0] :
                                                 start[OFFSET_W-1:0];
                        push_data.too_long     = 1'b0;
                        reported_next          = 1'b1;
                    end
                end
            end

            if (in_data.last_byte)
            begin
                // buffer end with no match so far: not-found result
                if (!push && !reported_reg)
                begin
                    push               = 1'b1;
                    push_data.found    = 1'b0;
                    push_data.match_offset = '0;
                    push_data.too_long = overflow_next;
                end
                seen_next     = '0;
                reported_next = 1'b0;
                overflow_next = 1'b0;
            end
        end
    end

    bps_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .has_room  (has_room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= '0;
            reported_reg <= 1'b0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            seen_reg     <= seen_next;
            reported_reg <= reported_next;
            overflow_reg <= overflow_next;
        end
    end

    // window bytes are only compared after this buffer has written them
    always_ff @(posedge clk)
    begin
        window_reg <= window_next;
    end

endmodule

// ----- design/bps_cfg_regs.sv -----
// Configuration register file of the byte pattern search block.
// Depends on bps_pkg.
module bps_cfg_regs
    import bps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PATTERN_LOW:    cfg_next.pattern_low    = cfg_data;
                CFG_PATTERN_HIGH:   cfg_next.pattern_high   = cfg_data;
                CFG_PATTERN_LENGTH: cfg_next.pattern_length = cfg_data[LEN_W-1:0];
                CFG_CASE_FOLD:      cfg_next.case_fold      = cfg_data[0];
                default:            cfg_next = cfg_reg;   // unmapped index ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_low    <= '0;
            cfg_reg.pattern_high   <= '0;
            cfg_reg.pattern_length <= LEN_W'(1);
            cfg_reg.case_fold      <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- design/bps_window_cmp.sv -----
// Parallel window compare: checks the newest bytes of the window against the pattern.
// Depends on bps_pkg.
module bps_window_cmp
    import bps_pkg::*;
(
    input  window_t          window,    // newest byte at position 0
    input  cfg_t             cfg,
    output logic [LEN_W-1:0] len_eff,
    output logic             hit
);

    window_t pattern;

    assign pattern = {cfg.pattern_high, cfg.pattern_low};

    always_comb
    begin
        len_eff = cfg.pattern_length;
        if (len_eff == '0)
            len_eff = LEN_W'(1);
        if (len_eff > LEN_MAX)
            len_eff = LEN_MAX;
    end

    // window position j pairs with pattern byte len-1-j
    always_comb
    begin
        logic [LEN_W-1:0]  pidx;
        logic [BYTE_W-1:0] wb;
        logic [BYTE_W-1:0] pb;
        hit = 1'b1;
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            pidx = len_eff - LEN_W'(j) - LEN_W'(1);
            wb   = fold_byte(window[j], cfg.case_fold);
            pb   = fold_byte(pattern[pidx[PIDX_W-1:0]], cfg.case_fold);
            if ((LEN_W'(j) < len_eff) && (wb != pb))
                hit = 1'b0;
        end
    end

endmodule

// ----- design/bps_out_buf.sv -----
// Two-entry result buffer (output register plus skid) for the search block.
// Depends on bps_pkg.
module bps_out_buf
    import bps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  out_item_t push_data,
    output logic      has_room,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic      head_valid_reg, head_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_item_t head_reg, head_next;
    out_item_t skid_reg, skid_next;
    logic      pop;

    assign pop       = head_valid_reg && out_ready;
    assign has_room  = !skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_data  = head_reg;

    always_comb
    begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                head_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!head_valid_reg || pop)
            begin
                head_next       = push_data;
                head_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            head_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule
